### src/pdd_pkg.sv
// Package: shared types, constants and helper functions of the page diff detector.
package pdd_pkg;

  localparam int unsigned PAGE_W   = 13;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [PAGE_W-1:0] MAX_PAGE_SIZE  = PAGE_W'(4096);
  localparam logic [PAGE_W-1:0] PAGE_SIZE_RST  = PAGE_W'(4096);
  localparam logic [CNT_W-1:0]  CNT_MAX        = '1;

  typedef enum logic {
    KIND_CHUNK   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] base_data;
    logic              base_present;
    logic [BYTE_W-1:0] tgt_data;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    kind_t             item_kind;
    logic [CNT_W-1:0]  page_number;
    logic [PAGE_W-1:0] chunk_length;
    logic [CNT_W-1:0]  payload_position;
    logic [CNT_W-1:0]  total_chunks;
    logic              final_item;
  } result_t;

  // Results produced by one byte: count (0..2) and the two slots in order.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  endfunction

endpackage

### src/pdd_if.sv
// Interfaces: byte input channel, result channel and page size write channel.
interface pdd_in_if;
  logic                       valid;
  logic                       ready;
  logic [pdd_pkg::BYTE_W-1:0] base_data;
  logic                       base_present;
  logic [pdd_pkg::BYTE_W-1:0] tgt_data;
  logic                       last_byte;

  modport source (output valid, base_data, base_present, tgt_data, last_byte,
                  input ready);
  modport sink   (input valid, base_data, base_present, tgt_data, last_byte,
                  output ready);
endinterface

interface pdd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       item_kind;
  logic [pdd_pkg::CNT_W-1:0]  page_number;
  logic [pdd_pkg::PAGE_W-1:0] chunk_length;
  logic [pdd_pkg::CNT_W-1:0]  payload_position;
  logic [pdd_pkg::CNT_W-1:0]  total_chunks;
  logic                       final_item;

  modport source (output valid, item_kind, page_number, chunk_length,
                  payload_position, total_chunks, final_item, input ready);
  modport sink   (input valid, item_kind, page_number, chunk_length,
                  payload_position, total_chunks, final_item, output ready);
endinterface

interface pdd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pdd_pkg::PAGE_W-1:0] pg_bytes;

  modport source (output valid, pg_bytes, input ready);
  modport sink   (input valid, pg_bytes, output ready);
endinterface

### src/pdd_core.sv
// Core: page size register, per-image counters and result generation for one byte.
module pdd_core (
  input  logic              clk,
  input  logic              rst_n,
  pdd_cfg_if.sink           cfg_ch,
  input  pdd_pkg::in_item_t item,
  input  logic              adv,
  output pdd_pkg::push_t    push
);
  import pdd_pkg::*;

  logic [PAGE_W-1:0] psz_r;
  logic [PAGE_W-1:0] off_r, off_nxt;
  logic [CNT_W-1:0]  page_r, page_nxt;
  logic              chg_r, chg_nxt;
  logic [CNT_W-1:0]  chunks_r, chunks_nxt;
  logic [CNT_W-1:0]  payload_r, payload_nxt;

  logic [BYTE_W-1:0] base_eff;
  logic              changed;
  logic [PAGE_W:0]   len;
  logic [PAGE_W-1:0] eff_size;
  logic              close;
  logic              chunk_emit;
  logic [CNT_W-1:0]  chunks_a, payload_a, page_a;
  result_t           chunk_res, sum_res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psz_r <= PAGE_SIZE_RST;
    end else if (cfg_ch.valid) begin
      psz_r <= cfg_ch.pg_bytes;
    end
  end

  always_comb begin
    base_eff = item.base_present ? item.base_data : '0;
    changed  = chg_r | (base_eff != item.tgt_data);
    len      = {1'b0, off_r} + (PAGE_W+1)'(1);
    if (psz_r == '0) begin
      eff_size = PAGE_W'(1);
    end else if (psz_r > MAX_PAGE_SIZE) begin
      eff_size = MAX_PAGE_SIZE;
    end else begin
      eff_size = psz_r;
    end
    close      = (len >= {1'b0, eff_size}) || item.last_byte;
    chunk_emit = close && changed;

    chunks_a  = chunk_emit ? sat_add(chunks_r, CNT_W'(1)) : chunks_r;
    payload_a = chunk_emit ? sat_add(payload_r, CNT_W'(len)) : payload_r;
    page_a    = close ? sat_add(page_r, CNT_W'(1)) : page_r;

    chunk_res.item_kind        = KIND_CHUNK;
    chunk_res.page_number      = page_r;
    chunk_res.chunk_length     = len[PAGE_W-1:0];
    chunk_res.payload_position = payload_r;
    chunk_res.total_chunks     = chunks_a;
    chunk_res.final_item       = !item.last_byte;

    sum_res.item_kind        = KIND_SUMMARY;
    sum_res.page_number      = '0;
    sum_res.chunk_length     = '0;
    sum_res.payload_position = payload_a;
    sum_res.total_chunks     = chunks_a;
    sum_res.final_item       = 1'b1;

    push.res0 = chunk_emit ? chunk_res : sum_res;
    push.res1 = sum_res;
    push.cnt  = adv ? ({1'b0, chunk_emit} + {1'b0, item.last_byte}) : 2'd0;

    off_nxt     = close ? '0 : len[PAGE_W-1:0];
    chg_nxt     = close ? 1'b0 : changed;
    page_nxt    = item.last_byte ? '0 : page_a;
    chunks_nxt  = item.last_byte ? '0 : chunks_a;
    payload_nxt = item.last_byte ? '0 : payload_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r     <= '0;
      page_r    <= '0;
      chg_r     <= 1'b0;
      chunks_r  <= '0;
      payload_r <= '0;
    end else if (adv) begin
      off_r     <= off_nxt;
      page_r    <= page_nxt;
      chg_r     <= chg_nxt;
      chunks_r  <= chunks_nxt;
      payload_r <= payload_nxt;
    end
  end

endmodule

### src/pdd_out_queue.sv
// Result queue: takes up to two results a cycle, hands out one per transfer.
module pdd_out_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  pdd_pkg::push_t push,
  output logic           room,
  pdd_out_if.source      out_ch
);
  import pdd_pkg::*;

  result_t           q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;
  logic [QPTR_W-1:0] wr_p1;
  result_t           head;

  assign room  = cnt_r <= QCNT_W'(QDEPTH - 2);
  assign pop   = out_ch.valid && out_ch.ready;
  assign wr_p1 = wr_r + QPTR_W'(1);

  always_comb begin
    wr_nxt  = wr_r + QPTR_W'(push.cnt);
    rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      q_r[wr_p1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head = q_r[rd_r];

  assign out_ch.valid            = cnt_r != '0;
  assign out_ch.item_kind        = head.item_kind;
  assign out_ch.page_number      = head.page_number;
  assign out_ch.chunk_length     = head.chunk_length;
  assign out_ch.payload_position = head.payload_position;
  assign out_ch.total_chunks     = head.total_chunks;
  assign out_ch.final_item       = head.final_item;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue count past depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> room)
    else $error("push into queue without room for two");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != QCNT_W'(QDEPTH) |-> cnt_r[QPTR_W-1:0] == QPTR_W'(wr_r - rd_r))
    else $error("queue pointers disagree with count");

  a_two_ends_summary: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> push.res1.item_kind == KIND_SUMMARY &&
                         push.res0.item_kind == KIND_CHUNK)
    else $error("pair of results not chunk then summary");

endmodule

### src/page_diff_detector.sv
// Top level: page diff detector, byte pair stream in, chunk descriptors out.
// Usage:
//   in_ch  - one target byte per transfer, with the base byte at the same
//            offset, a flag saying whether the base reaches that offset, and
//            a flag marking the last byte of the target image.
//   out_ch - chunk descriptors for changed pages, each sent when its page
//            closes (full or at the last byte), then one summary after the
//            last byte with the chunk count and total payload length.
//   cfg_ch - page size writes (0 acts as 1, above 4096 clamps to 4096);
//            always ready, write only while the block is idle.
// Path: a byte's results reach out_ch through the input register, then
// the result queue; the byte waits in the input register while the queue
// lacks room for two results.
// Throughput: one byte per cycle while the queue has room for two results;
// a chunk and the summary from one byte fill two slots of the four-entry result queue.
// Reset (rst_n low, synchronous): page size returns to 4096, all page and
// image counters clear, the queue empties.
// Stall: when out_ch is not ready the queue fills; the input register holds
// its byte while fewer than two free queue slots remain, and in_ch.ready
// drops once the input register is also full. Nothing is lost or repeated.
module page_diff_detector (
  input  logic      clk,
  input  logic      rst_n,
  pdd_in_if.sink    in_ch,
  pdd_out_if.source out_ch,
  pdd_cfg_if.sink   cfg_ch
);
  import pdd_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r;
  logic     s1_adv;
  logic     q_room;
  logic     in_xfer;
  push_t    push;

  // Advance the held byte whenever the queue can take two results.
  assign s1_adv      = s1_valid_r && q_room;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture the payload on every input transfer; no reset needed.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.base_data    <= in_ch.base_data;
      s1_item_r.base_present <= in_ch.base_present;
      s1_item_r.tgt_data     <= in_ch.tgt_data;
      s1_item_r.last_byte    <= in_ch.last_byte;
    end
  end

  pdd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .item   (s1_item_r),
    .adv    (s1_adv),
    .push   (push)
  );

  pdd_out_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (q_room),
    .out_ch (out_ch)
  );

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !q_room |=> s1_valid_r && $stable(s1_item_r))
    else $error("held byte lost while queue was full");

  a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> push.cnt == 2'd0)
    else $error("results pushed with no byte held");

  a_last_gives_summary: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_item_r.last_byte |-> push.cnt != 2'd0)
    else $error("last byte produced no summary");

endmodule

### tb/sv/page_diff_checker.sv
// Checker: watches the page diff detector's channels, predicts each result and compares.
module page_diff_checker (
  input  logic        clk,
  input  logic        rst_n,
  pdd_in_if           in_ch,
  pdd_out_if          out_ch,
  pdd_cfg_if          cfg_ch,
  output int unsigned fail_count,
  output int unsigned awaited,
  output int unsigned bytes_seen,
  output int unsigned chunks_seen,
  output int unsigned summaries_seen
);
  import pdd_pkg::*;

  logic [PAGE_W-1:0] size_reg;
  logic [PAGE_W-1:0] page_fill;
  logic [CNT_W-1:0]  page_idx;
  logic [CNT_W-1:0]  chunk_cnt;
  logic [CNT_W-1:0]  payload_len;
  logic              page_dirty;
  result_t           due_results[$];

  initial begin
    fail_count     = 0;
    awaited        = 0;
    bytes_seen     = 0;
    chunks_seen    = 0;
    summaries_seen = 0;
  end

  function automatic logic [CNT_W-1:0] clip_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    return (a > CNT_MAX - b) ? CNT_MAX : a + b;
  endfunction

  // Fold one byte into the page state and queue the results it closes.
  task automatic take_byte(input in_item_t b);
    logic [BYTE_W-1:0] against;
    logic [PAGE_W-1:0] eff_size;
    logic [PAGE_W-1:0] fill_next;
    result_t           r;
    against = b.base_present ? b.base_data : '0;
    if (against != b.tgt_data) page_dirty = 1'b1;
    if (size_reg == '0)                eff_size = PAGE_W'(1);
    else if (size_reg > MAX_PAGE_SIZE) eff_size = MAX_PAGE_SIZE;
    else                               eff_size = size_reg;
    fill_next = page_fill + PAGE_W'(1);
    if (fill_next >= eff_size || b.last_byte) begin
      if (page_dirty) begin
        chunk_cnt          = clip_add(chunk_cnt, CNT_W'(1));
        r.item_kind        = KIND_CHUNK;
        r.page_number      = page_idx;
        r.chunk_length     = fill_next;
        r.payload_position = payload_len;
        r.total_chunks     = chunk_cnt;
        r.final_item       = !b.last_byte;
        due_results.push_back(r);
        payload_len = clip_add(payload_len, CNT_W'(fill_next));
      end
      page_idx   = clip_add(page_idx, CNT_W'(1));
      page_fill  = '0;
      page_dirty = 1'b0;
    end else begin
      page_fill = fill_next;
    end
    if (b.last_byte) begin
      r.item_kind        = KIND_SUMMARY;
      r.page_number      = '0;
      r.chunk_length     = '0;
      r.payload_position = payload_len;
      r.total_chunks     = chunk_cnt;
      r.final_item       = 1'b1;
      due_results.push_back(r);
      page_idx    = '0;
      chunk_cnt   = '0;
      payload_len = '0;
    end
  endtask

  task automatic compare_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, kind %0h page %0h length %0h position %0h",
               $time, out_ch.item_kind, out_ch.page_number, out_ch.chunk_length,
               out_ch.payload_position);
      return;
    end
    want = due_results.pop_front();
    compare_field("item_kind", CNT_W'(want.item_kind), CNT_W'(out_ch.item_kind));
    compare_field("page_number", want.page_number, out_ch.page_number);
    compare_field("chunk_length", CNT_W'(want.chunk_length), CNT_W'(out_ch.chunk_length));
    compare_field("payload_position", want.payload_position, out_ch.payload_position);
    compare_field("total_chunks", want.total_chunks, out_ch.total_chunks);
    compare_field("final_item", CNT_W'(want.final_item), CNT_W'(out_ch.final_item));
    if (want.item_kind == KIND_CHUNK) chunks_seen++;
    else summaries_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      size_reg    = PAGE_SIZE_RST;
      page_fill   = '0;
      page_idx    = '0;
      chunk_cnt   = '0;
      payload_len = '0;
      page_dirty  = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) size_reg = cfg_ch.pg_bytes;
      if (in_ch.valid && in_ch.ready) begin
        bytes_seen++;
        take_byte(in_item_t'{in_ch.base_data, in_ch.base_present,
                             in_ch.tgt_data, in_ch.last_byte});
      end
      if (out_ch.valid && out_ch.ready) check_result();
    end
    awaited = due_results.size();
  end

endmodule

### tb/sv/page_diff_detector_test.sv
// Testbench top: stimulus, idling and verdict for the page diff detector.
module page_diff_detector_test;
  import pdd_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  localparam int PHASES         = 12;
  localparam int PHASE_BYTES    = 150;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 4;

  // Page size per random phase: extremes, out-of-range writes and small sizes.
  localparam int PHASE_SIZES [PHASES] = '{3, 1, 8191, 0, 1, 4096, 2, 4097, 5, 16, 7, 64};

  logic clk = 1'b0;
  logic rst_n;

  int          src_idle_pct = 0;
  int          stall_pct    = 0;
  logic        hold_rx      = 1'b0;
  int          img_left     = 0;
  int          img_diff_pct = 0;
  int unsigned size_writes  = 0;

  int unsigned fail_count;
  int unsigned awaited;
  int unsigned bytes_seen;
  int unsigned chunks_seen;
  int unsigned summaries_seen;

  pdd_in_if  in_ch ();
  pdd_out_if out_ch ();
  pdd_cfg_if cfg_ch ();

  page_diff_detector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  page_diff_checker watch (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .fail_count     (fail_count),
    .awaited        (awaited),
    .bytes_seen     (bytes_seen),
    .chunks_seen    (chunks_seen),
    .summaries_seen (summaries_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run (every byte gapped, every
  // result stalled, two results per byte, plus the long hold).
  initial begin
    #5_000_000;
    $display("timed out before the block drained");
    $display("[page_diff_detector] ERROR");
    $finish;
  end

  // Receiver: one ready decision per cycle. The pressure hold forces ready
  // low regardless of the stall rate.
  initial begin
    forever begin
      out_ch.ready <= !hold_rx && ($urandom_range(0, 99) >= stall_pct);
      @(posedge clk);
    end
  end

  // Offer one byte, with random idle cycles ahead of it, and return at the
  // edge where it transfers. Valid stays high so back-to-back bytes need no
  // second assignment in the same step.
  task automatic send_byte(input logic [7:0] base, input logic present,
                           input logic [7:0] target, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.base_data    <= base;
    in_ch.base_present <= present;
    in_ch.tgt_data     <= target;
    in_ch.last_byte    <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait at the falling edge (after the checker has logged every
  // transfer) until no result is owed, then give the pipe time to empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size_reg(input logic [PAGE_W-1:0] size);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.pg_bytes <= size;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    size_writes++;
  endtask

  // Next byte of a random image. Images run on across phase boundaries, so
  // a new page size often lands in the middle of a page.
  task automatic send_random_byte();
    logic [7:0] base;
    logic [7:0] target;
    logic       present;
    if (img_left == 0) begin
      img_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(25, 120))
                                              : int'($urandom_range(1, 24));
      case ($urandom_range(0, 3))
        0:       img_diff_pct = 0;
        1:       img_diff_pct = 2;
        2:       img_diff_pct = 25;
        default: img_diff_pct = 100;
      endcase
    end
    present = ($urandom_range(0, 4) != 0);
    base    = 8'($urandom);
    if ($urandom_range(0, 99) < img_diff_pct) target = 8'($urandom);
    else                                      target = present ? base : 8'h00;
    send_byte(base, present, target, img_left == 1);
    img_left--;
  endtask

  initial begin
    idle_mode_t mode;

    in_ch.valid        <= 1'b0;
    in_ch.base_data    <= '0;
    in_ch.base_present <= 1'b0;
    in_ch.tgt_data     <= '0;
    in_ch.last_byte    <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.pg_bytes    <= '0;
    rst_n              <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset page size: a short image whose last byte differs closes page 0.
    send_byte(8'h00, 1'b1, 8'h00, 1'b0);
    send_byte(8'hFF, 1'b1, 8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1, 8'hA5, 1'b1);
    settle();

    // Size zero acts as one: every byte is a page; clean page still counts.
    write_size_reg(PAGE_W'(0));
    send_byte(8'h12, 1'b1, 8'h34, 1'b0);
    send_byte(8'h77, 1'b1, 8'h77, 1'b1);
    settle();

    // Oversize clamps to the maximum. Base absent: compare against zero,
    // whatever the base byte holds. Then an image with no change at all.
    write_size_reg(PAGE_W'(8191));
    send_byte(8'hAB, 1'b0, 8'h00, 1'b0);
    send_byte(8'hFF, 1'b0, 8'hFF, 1'b1);
    send_byte(8'hAB, 1'b0, 8'h00, 1'b1);
    settle();

    // Size two: changed, clean, then a full page closing on the last byte
    // (chunk and summary from one byte).
    write_size_reg(PAGE_W'(2));
    send_byte(8'h01, 1'b1, 8'h01, 1'b0);
    send_byte(8'h02, 1'b1, 8'h03, 1'b0);
    send_byte(8'h04, 1'b1, 8'h04, 1'b0);
    send_byte(8'h05, 1'b1, 8'h05, 1'b0);
    send_byte(8'h06, 1'b1, 8'h07, 1'b0);
    send_byte(8'h08, 1'b1, 8'h09, 1'b1);
    settle();

    // Shrink the page size mid-page: the open page closes on the next byte.
    write_size_reg(PAGE_W'(8));
    send_byte(8'h10, 1'b1, 8'h10, 1'b0);
    send_byte(8'h11, 1'b1, 8'h11, 1'b0);
    send_byte(8'h12, 1'b1, 8'h12, 1'b0);
    send_byte(8'h13, 1'b1, 8'h13, 1'b0);
    send_byte(8'h14, 1'b1, 8'h14, 1'b0);
    settle();
    write_size_reg(PAGE_W'(3));
    send_byte(8'h00, 1'b1, 8'h01, 1'b0);
    send_byte(8'h00, 1'b1, 8'h00, 1'b1);
    settle();

    // Random phases: rotate the idle mix, change the page size between them.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_size_reg(PAGE_W'(PHASE_SIZES[ph]));
      mode = idle_mode_t'(ph % 4);
      src_idle_pct = (mode == IDLE_SENDER) ? 83 : (mode == IDLE_BOTH) ? 29 : 0;
      stall_pct   <= (mode == IDLE_RECEIVER) ? 83 : (mode == IDLE_BOTH) ? 29 : 0;
      // Hold the receiver off while the sender streams: the queue fills and
      // the block has to stall its input.
      if (ph == PRESSURE_PHASE) begin
        fork
          begin
            hold_rx <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rx <= 1'b0;
          end
        join_none
      end
      repeat (PHASE_BYTES) send_random_byte();
      settle();
    end

    // Finish the open image so the run ends on a summary.
    src_idle_pct = 0;
    stall_pct   <= 0;
    while (img_left != 0) send_random_byte();
    settle();
    repeat (8) @(posedge clk);

    $display("run covered %0d bytes under %0d page size writes (0, 1..64, 4096, 4097, 8191)",
             bytes_seen, size_writes);
    $display("checked %0d chunk descriptors and %0d image summaries, idle mixes and one long hold",
             chunks_seen, summaries_seen);
    if (fail_count == 0) begin
      $display("[page_diff_detector] OK");
    end else begin
      $display("[page_diff_detector] ERROR");
    end
    $finish;
  end

endmodule
